FILE: rtl/tgbr_pkg.sv
package tgbr_pkg;

    // window bound default
    localparam int MAX_WIN_SAMPLES_DEF = 16;

    // field widths
    localparam int SAMPLE_W   = 24;
    localparam int TIME_W     = 32;
    localparam int BRI_W      = 8;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX_MS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS            = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_CLICK_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP_MS      = 3'd5;

    // register reset values
    localparam logic [23:0] THRESHOLD_RST   = 24'd250;
    localparam logic [15:0] WINDOW_MS_RST   = 16'd25;
    localparam logic [15:0] CLICK_MAX_RST   = 16'd500;
    localparam logic [15:0] GAP_MS_RST      = 16'd250;
    localparam logic [7:0]  RESET_CLICK_RST = 8'd20;
    localparam logic [7:0]  RAMP_STEP_RST   = 8'd15;

    // brightness step bands
    localparam logic [BRI_W-1:0] BRI_BAND_LOW  = 8'd30;
    localparam logic [BRI_W-1:0] BRI_BAND_MID  = 8'd140;
    localparam logic [BRI_W-1:0] BRI_BAND_HIGH = 8'd190;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_CLICK  = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_RESET  = 3'd3,
        EV_BRIGHT = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_DEC,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic acc;
        logic mul;
        logic decide;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ok;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/tgbr_ifs.sv
interface tgbr_in_if;
    import tgbr_pkg::*;
    logic                valid;
    logic                ready;
    logic                sample_ok;
    logic [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]   now_ms;
    logic                light_on;
    logic [BRI_W-1:0]    current_brightness;

    modport source (output valid, sample_ok, sample_value, now_ms, light_on,
                    current_brightness, input ready);
    modport sink   (input valid, sample_ok, sample_value, now_ms, light_on,
                    current_brightness, output ready);
endinterface

interface tgbr_out_if;
    import tgbr_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       event_res;
    logic [BRI_W-1:0] new_brightness;
    logic             switch_on;

    modport source (output valid, event_res, new_brightness, switch_on, input ready);
    modport sink   (input valid, event_res, new_brightness, switch_on, output ready);
endinterface

interface tgbr_cfg_if;
    import tgbr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tgbr_ctrl.sv
module tgbr_ctrl
    import tgbr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = i_stat.ok ? ST_MUL : ST_EMIT;
            end
            ST_MUL: begin
                n_state = ST_DEC;
            end
            ST_DEC: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_ACC: begin
                o_cmd.acc = i_stat.ok;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_DEC: begin
                o_cmd.decide = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/tgbr_dp.sv
module tgbr_dp
    import tgbr_pkg::*;
#(
    parameter int MAX_WINDOW_SAMPLES = MAX_WIN_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    // input word
    input  logic                  i_sample_ok,
    input  logic [SAMPLE_W-1:0]   i_sample_value,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic                  i_light_on,
    input  logic [BRI_W-1:0]      i_current_brightness,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // result word
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [2:0]            o_event_res,
    output logic [BRI_W-1:0]      o_new_brightness,
    output logic                  o_switch_on
);

    localparam int CNT_W  = $clog2(MAX_WINDOW_SAMPLES + 1);
    localparam int PROD_W = SAMPLE_W + 1 + CNT_W;
    localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW_SAMPLES);

    // configuration
    logic [23:0] r_threshold;
    logic [15:0] r_window_ms;
    logic [15:0] r_click_max_ms;
    logic [15:0] r_gap_ms;
    logic [7:0]  r_reset_clicks;
    logic [7:0]  r_ramp_step_ms;

    // latched input word
    logic                r_ok;
    logic [SAMPLE_W-1:0] r_sample;
    logic [TIME_W-1:0]   r_now;
    logic                r_lit;
    logic [BRI_W-1:0]    r_bri;

    // detector state
    logic              r_pressed,      n_pressed;
    logic              r_long_first,   n_long_first;
    logic [TIME_W-1:0] r_window_start, n_window_start;
    logic [TIME_W-1:0] r_down_time,    n_down_time;
    logic [TIME_W-1:0] r_up_time,      n_up_time;
    logic [7:0]        r_click_count,  n_click_count;
    logic [7:0]        r_ramp_time,    n_ramp_time;
    logic              r_ramp_up,      n_ramp_up;
    logic [SUM_W-1:0]  r_sum,          n_sum;
    logic [CNT_W-1:0]  r_cnt,          n_cnt;
    logic              r_skip,         n_skip;

    // threshold products
    logic [PROD_W-1:0] r_prod_lo;
    logic [PROD_W-1:0] r_prod_hi;

    // result register
    logic             r_out_valid, n_out_valid;
    t_event           r_out_event, n_out_event;
    logic [BRI_W-1:0] r_out_bri,   n_out_bri;
    logic             r_out_on,    n_out_on;

    // decision and gesture terms
    logic             win_hit;
    logic             avg_below;
    logic             avg_above;
    logic             long_elapsed;
    logic             gap_hit;
    logic             long_hit;
    logic             first;
    logic             too_early;
    logic [BRI_W-1:0] bri_base;
    logic [BRI_W-1:0] step;
    logic [BRI_W:0]   bri_up_sum;
    logic             rup_base;
    logic             rup_fin;
    logic [BRI_W-1:0] bri_next;
    t_event           click_event;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RST;
            r_window_ms    <= WINDOW_MS_RST;
            r_click_max_ms <= CLICK_MAX_RST;
            r_gap_ms       <= GAP_MS_RST;
            r_reset_clicks <= RESET_CLICK_RST;
            r_ramp_step_ms <= RAMP_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOUCH_THRESHOLD:   r_threshold    <= i_cfg_data[23:0];
                CFG_WINDOW_MS:         r_window_ms    <= i_cfg_data[15:0];
                CFG_CLICK_MAX_MS:      r_click_max_ms <= i_cfg_data[15:0];
                CFG_GAP_MS:            r_gap_ms       <= i_cfg_data[15:0];
                CFG_RESET_CLICK_COUNT: r_reset_clicks <= i_cfg_data[7:0];
                CFG_RAMP_STEP_MS:      r_ramp_step_ms <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input capture and products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ok     <= i_sample_ok;
            r_sample <= i_sample_value;
            r_now    <= i_now_ms;
            r_lit    <= i_light_on;
            r_bri    <= i_current_brightness;
        end
        if (i_cmd.mul) begin
            r_prod_lo <= PROD_W'(r_threshold) * PROD_W'(r_cnt);
            r_prod_hi <= PROD_W'({1'b0, r_threshold} + 25'd1) * PROD_W'(r_cnt);
        end
    end

    // floor(sum/cnt) < thr iff sum < thr*cnt; > thr iff sum >= (thr+1)*cnt
    assign avg_below = CMP_W'(r_sum) < CMP_W'(r_prod_lo);
    assign avg_above = CMP_W'(r_sum) >= CMP_W'(r_prod_hi);
    assign win_hit   = (r_now - r_window_start) >= TIME_W'(r_window_ms);

    assign long_elapsed = (r_now - r_down_time) > TIME_W'(r_click_max_ms);
    assign gap_hit      = !r_pressed && ((r_now - r_up_time) > TIME_W'(r_gap_ms));
    assign long_hit     = r_pressed && long_elapsed;

    // click sequence event
    always_comb begin
        if (r_click_count == 8'd1) begin
            click_event = EV_CLICK;
        end else if (r_click_count == 8'd2) begin
            click_event = EV_DOUBLE;
        end else if (r_click_count >= r_reset_clicks) begin
            click_event = EV_RESET;
        end else begin
            click_event = EV_NONE;
        end
    end

    // ramp step
    assign first     = r_long_first;
    assign too_early = !first && (8'(r_now[7:0] - r_ramp_time) < r_ramp_step_ms);
    assign bri_base  = (first && !r_lit) ? '0 : r_bri;
    assign rup_base  = first ? (!r_lit || !r_ramp_up) : r_ramp_up;

    always_comb begin
        if (bri_base < BRI_BAND_LOW) begin
            step = 8'd1;
        end else if (bri_base > BRI_BAND_MID && bri_base < BRI_BAND_HIGH) begin
            step = 8'd3;
        end else if (bri_base >= BRI_BAND_HIGH) begin
            step = 8'd4;
        end else begin
            step = 8'd2;
        end
    end

    // reverse at either end
    assign bri_up_sum = {1'b0, bri_base} + {1'b0, step};
    always_comb begin
        if (bri_up_sum[BRI_W]) begin
            rup_fin = 1'b0;
        end else if (bri_base < step) begin
            rup_fin = 1'b1;
        end else begin
            rup_fin = rup_base;
        end
    end
    assign bri_next = rup_fin ? bri_up_sum[BRI_W-1:0] : (bri_base - step);

    // next state of detector and result
    always_comb begin
        n_pressed      = r_pressed;
        n_long_first   = r_long_first;
        n_window_start = r_window_start;
        n_down_time    = r_down_time;
        n_up_time      = r_up_time;
        n_click_count  = r_click_count;
        n_ramp_time    = r_ramp_time;
        n_ramp_up      = r_ramp_up;
        n_sum          = r_sum;
        n_cnt          = r_cnt;
        n_skip         = r_skip;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_event    = r_out_event;
        n_out_bri      = r_out_bri;
        n_out_on       = r_out_on;

        if (i_cmd.load) begin
            n_skip = 1'b0;
        end

        // window accumulate, full window drops the sample
        if (i_cmd.acc && r_cnt < CNT_MAX) begin
            n_sum = r_sum + SUM_W'(r_sample);
            n_cnt = r_cnt + 1'b1;
        end

        // touch decision at window end
        if (i_cmd.decide && win_hit) begin
            if (r_cnt == '0) begin
                n_skip = 1'b1;
            end else begin
                if (r_pressed && avg_below) begin
                    n_pressed    = 1'b0;
                    n_long_first = 1'b0;
                    n_click_count = long_elapsed ? 8'd0 : (r_click_count + 8'd1);
                    n_up_time    = r_now;
                end else if (!r_pressed && avg_above) begin
                    n_pressed    = 1'b1;
                    n_long_first = 1'b1;
                    n_down_time  = r_now;
                end
                n_sum          = '0;
                n_cnt          = '0;
                n_window_start = r_now;
            end
        end

        // gesture and result word
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_event = EV_NONE;
            n_out_bri   = '0;
            n_out_on    = 1'b0;
            if (r_ok && !r_skip) begin
                if (gap_hit) begin
                    n_out_event   = click_event;
                    n_click_count = 8'd0;
                end else if (long_hit) begin
                    n_long_first = 1'b0;
                    if (!too_early) begin
                        n_ramp_up   = rup_fin;
                        n_ramp_time = r_now[7:0];
                        n_out_event = EV_BRIGHT;
                        n_out_bri   = bri_next;
                        n_out_on    = first && !r_lit;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed      <= 1'b0;
            r_long_first   <= 1'b0;
            r_window_start <= '0;
            r_down_time    <= '0;
            r_up_time      <= '0;
            r_click_count  <= 8'd1;
            r_ramp_time    <= '0;
            r_ramp_up      <= 1'b0;
            r_sum          <= '0;
            r_cnt          <= '0;
            r_skip         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_pressed      <= n_pressed;
            r_long_first   <= n_long_first;
            r_window_start <= n_window_start;
            r_down_time    <= n_down_time;
            r_up_time      <= n_up_time;
            r_click_count  <= n_click_count;
            r_ramp_time    <= n_ramp_time;
            r_ramp_up      <= n_ramp_up;
            r_sum          <= n_sum;
            r_cnt          <= n_cnt;
            r_skip         <= n_skip;
            r_out_valid    <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_event <= n_out_event;
        r_out_bri   <= n_out_bri;
        r_out_on    <= n_out_on;
    end

    assign o_stat.ok       = r_ok;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_out_event;
    assign o_new_brightness = r_out_bri;
    assign o_switch_on      = r_out_on;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("window sample count beyond bound");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("result word lost after emit");

    a_quiet_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_event != EV_BRIGHT |-> r_out_bri == '0 && !r_out_on)
        else $error("brightness payload without brightness event");

    a_release_at_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_pressed) |-> $past(i_cmd.decide))
        else $error("release outside window decision");

endmodule

FILE: rtl/touch_gesture_brightness_ramp_top.sv
// channel   dir  modport  payload
// i_in      in   sink     sample_ok, sample_value, now_ms, light_on, current_brightness
// o_out     out  source   event_res, new_brightness, switch_on
// i_cfg     in   sink     index (3b), data (24b); ready whenever out of reset
//
// a word is accepted only while the controller is idle; its result is registered by the
// controller sequence load, accumulate, multiply, decide, emit, which skips multiply and
// decide for a failed sample, one word in flight at a time.
// the next word is accepted while the result waits in the output register.
// a stalled result holds the controller in its emit step until taken.
// synchronous active-low reset restores configuration, detector and controller state, no clearing pass.
module touch_gesture_brightness_ramp_top
    import tgbr_pkg::*;
#(
    parameter int MAX_WINDOW_SAMPLES = MAX_WIN_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tgbr_in_if.sink     i_in,
    tgbr_out_if.source  o_out,
    tgbr_cfg_if.sink    i_cfg
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // handshakes, nothing taken while in reset
    assign i_in.ready  = in_ready && i_rst_n;
    assign i_cfg.ready = i_rst_n;

    tgbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    tgbr_dp #(
        .MAX_WINDOW_SAMPLES (MAX_WINDOW_SAMPLES)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_sample_ok          (i_in.sample_ok),
        .i_sample_value       (i_in.sample_value),
        .i_now_ms             (i_in.now_ms),
        .i_light_on           (i_in.light_on),
        .i_current_brightness (i_in.current_brightness),
        .i_cfg_we             (i_cfg.valid),
        .i_cfg_idx            (i_cfg.index),
        .i_cfg_data           (i_cfg.data),
        .i_out_ready          (o_out.ready),
        .o_out_valid          (o_out.valid),
        .o_event_res          (o_out.event_res),
        .o_new_brightness     (o_out.new_brightness),
        .o_switch_on          (o_out.switch_on)
    );

endmodule
